// ----- rtl/tbfs_pkg.sv -----
package tbfs_pkg;

  // Widths of the fixed payload fields.
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned TREE_W    = 2;
  localparam int unsigned CFG_DIM_W = 5;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned ADDR_W    = 4;

  // The row/column split of an 8-bit node number is a restoring divider
  // that retires this many quotient bits in each pipeline stage.
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = DATA_W / STEPS_PER_STAGE;

  typedef enum logic [TREE_W-1:0] {
    TREE_RIGHT = 2'd0,
    TREE_DOWN  = 2'd1,
    TREE_LEFT  = 2'd2,
    TREE_UP    = 2'd3
  } tree_e;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_NODE_ID = 2'd2
  } reg_e;

  typedef struct packed {
    logic  valid;
    tree_e tree;
  } ctl_t;

endpackage

// ----- rtl/torus_broadcast_forward_select_core.sv -----
// A start beat passes the capture stage, the divider stages and the decision register before its result beat.
// Throughput: one start beat per cycle; busy_o is never raised.
// The receiver cannot stall, so results leave on the done_o strobe as made.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores
// columns = 4, rows = 4 and node_id = 0.
module torus_broadcast_forward_select_core #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port.
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [tbfs_pkg::ADDR_W-1:0]     paddr_i,
  input  logic [tbfs_pkg::APB_W-1:0]      pwdata_i,
  output logic [tbfs_pkg::APB_W-1:0]      prdata_o,
  output logic                            pready_o,
  // Packet header beats.
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tbfs_pkg::TREE_W-1:0]     tree_sel_i,
  input  logic [tbfs_pkg::DATA_W-1:0]     source_node_i,
  // Forwarding decision beats.
  output logic                            done_o,
  output logic                            fwd_right_o,
  output logic                            fwd_down_o,
  output logic                            fwd_left_o,
  output logic                            fwd_up_o,
  output logic                            deliver_local_o
);
  import tbfs_pkg::*;

  // A clamped dimension runs from 1 to MAX_DIM.
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  // Capture stage, divider stages, decision register.
  localparam int unsigned LATENCY = DIV_STAGES + 2;

  // ---------------------------------------------------------------------
  // Configuration registers. The user must write them only while the block
  // is idle (not enforced); the pipeline samples them once, at capture.
  // ---------------------------------------------------------------------
  logic [CFG_DIM_W-1:0] columns_q, rows_q;
  logic [DATA_W-1:0]    node_id_q;
  logic                 cfg_write;
  reg_e                 cfg_reg;

  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i;
  assign cfg_reg   = reg_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= CFG_DIM_W'(4);
      rows_q    <= CFG_DIM_W'(4);
      node_id_q <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_COLUMNS: columns_q <= pwdata_i[CFG_DIM_W-1:0];
        REG_ROWS:    rows_q    <= pwdata_i[CFG_DIM_W-1:0];
        REG_NODE_ID: node_id_q <= pwdata_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_COLUMNS: prdata_o = APB_W'(columns_q);
      REG_ROWS:    prdata_o = APB_W'(rows_q);
      REG_NODE_ID: prdata_o = APB_W'(node_id_q);
      default:     prdata_o = '0;
    endcase
  end

  // A dimension of zero counts as one, and anything above MAX_DIM as
  // MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    begin
      if (v == '0) begin
        clamp_dim = DIM_W'(1);
      end else if (int'(v) > int'(MAX_DIM)) begin
        clamp_dim = DIM_W'(MAX_DIM);
      end else begin
        clamp_dim = DIM_W'(v);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Capture stage. Nothing ever holds the pipeline, so a start beat is
  // taken in every cycle.
  // ---------------------------------------------------------------------
  assign busy_o = 1'b0;

  ctl_t              ctl   [DIV_STAGES+1];
  logic [DIM_W-1:0]  cols  [DIV_STAGES+1];
  logic [DIM_W-1:0]  rows  [DIV_STAGES+1];
  logic [DATA_W-1:0] src_qd  [DIV_STAGES+1];
  logic [DIM_W-1:0]  src_rem [DIV_STAGES+1];
  logic [DATA_W-1:0] node_qd  [DIV_STAGES+1];
  logic [DIM_W-1:0]  node_rem [DIV_STAGES+1];

  logic              cap_valid_q;
  tree_e             cap_tree_q;
  logic [DIM_W-1:0]  cap_cols_q, cap_rows_q;
  logic [DATA_W-1:0] cap_src_q, cap_node_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else begin
      cap_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_tree_q <= tree_e'(tree_sel_i);
    cap_cols_q <= clamp_dim(columns_q);
    cap_rows_q <= clamp_dim(rows_q);
    cap_src_q  <= source_node_i;
    cap_node_q <= node_id_q;
  end

  assign ctl[0]      = '{valid: cap_valid_q, tree: cap_tree_q};
  assign cols[0]     = cap_cols_q;
  assign rows[0]     = cap_rows_q;
  assign src_qd[0]   = cap_src_q;
  assign src_rem[0]  = '0;
  assign node_qd[0]  = cap_node_q;
  assign node_rem[0] = '0;

  // ---------------------------------------------------------------------
  // Divider pipeline. Both the source and this node are split into row
  // (quotient) and column (remainder) by the column count, side by side,
  // a couple of quotient bits per stage.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tbfs_div_stage #(
      .DIM_W (DIM_W)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[g]),
      .cols_i     (cols[g]),
      .rows_i     (rows[g]),
      .src_qd_i   (src_qd[g]),
      .src_rem_i  (src_rem[g]),
      .node_qd_i  (node_qd[g]),
      .node_rem_i (node_rem[g]),
      .ctl_o      (ctl[g+1]),
      .cols_o     (cols[g+1]),
      .rows_o     (rows[g+1]),
      .src_qd_o   (src_qd[g+1]),
      .src_rem_o  (src_rem[g+1]),
      .node_qd_o  (node_qd[g+1]),
      .node_rem_o (node_rem[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Decision stage. With rows and columns known, the tree rules are a few
  // narrow compares.
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]  c, r, mc, sc, mr, sr;
  logic [DIM_W-1:0]  rc, lc, dr, ur;
  logic [DIM_W:0]    mc_inc, mr_inc;
  logic              in_range, self_node;
  logic              fr_d, fd_d, fl_d, fu_d;
  tree_e             tree;

  assign c    = cols[DIV_STAGES];
  assign r    = rows[DIV_STAGES];
  assign mc   = node_rem[DIV_STAGES];
  assign sc   = src_rem[DIV_STAGES];
  assign tree = ctl[DIV_STAGES].tree;

  // A node lies inside the torus exactly when its row is below the row
  // count; then the row also fits the narrow dimension width.
  assign in_range = (node_qd[DIV_STAGES] < DATA_W'(r)) &&
                    (src_qd[DIV_STAGES] < DATA_W'(r));
  assign mr = node_qd[DIV_STAGES][DIM_W-1:0];
  assign sr = src_qd[DIV_STAGES][DIM_W-1:0];

  // Cyclic neighbor coordinates.
  assign mc_inc = {1'b0, mc} + 1'b1;
  assign mr_inc = {1'b0, mr} + 1'b1;
  assign rc = (mc_inc == {1'b0, c}) ? '0 : mc_inc[DIM_W-1:0];
  assign dr = (mr_inc == {1'b0, r}) ? '0 : mr_inc[DIM_W-1:0];
  assign lc = (mc == '0) ? c - 1'b1 : mc - 1'b1;
  assign ur = (mr == '0) ? r - 1'b1 : mr - 1'b1;

  assign self_node = (mr == sr) && (mc == sc);

  always_comb begin
    logic near;
    logic wide_c, wide_r;
    near   = 1'b0;
    wide_c = (c > DIM_W'(1));
    wide_r = (r > DIM_W'(1));
    fr_d   = 1'b0;
    fd_d   = 1'b0;
    fl_d   = 1'b0;
    fu_d   = 1'b0;
    if (in_range) begin
      unique case (tree)
        TREE_RIGHT: begin
          // The source column is just right of this node.
          near = (sc == rc) && wide_c;
          if (self_node) begin
            fr_d = wide_c;
          end else if ((mr == sr) || near) begin
            fr_d = !((mr == sr) && (rc == sc));
            fd_d = (dr != sr);
          end else if ((mc != sc) && (dr != sr)) begin
            fd_d = 1'b1;
          end
        end
        TREE_DOWN: begin
          // The source row is just below this node.
          near = (sr == dr) && wide_r;
          if (self_node) begin
            fd_d = wide_r;
          end else if ((mc == sc) || near) begin
            fd_d = !((mc == sc) && (dr == sr));
            fl_d = (lc != sc);
          end else if ((mr != sr) && (lc != sc)) begin
            fl_d = 1'b1;
          end
        end
        TREE_LEFT: begin
          // The source column is just left of this node.
          near = (sc == lc) && wide_c;
          if (self_node) begin
            fl_d = wide_c;
          end else if ((mr == sr) || near) begin
            fl_d = !((mr == sr) && (lc == sc));
            fu_d = (ur != sr);
          end else if ((mc != sc) && (ur != sr)) begin
            fu_d = 1'b1;
          end
        end
        TREE_UP: begin
          // The source row is just above this node.
          near = (sr == ur) && wide_r;
          if (self_node) begin
            fu_d = wide_r;
          end else if ((mc == sc) || near) begin
            fu_d = !((mc == sc) && (ur == sr));
            fr_d = (rc != sc);
          end else if ((mr != sr) && (rc != sc)) begin
            fr_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  logic done_q;
  logic fr_q, fd_q, fl_q, fu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
    fd_q <= fd_d;
    fl_q <= fl_d;
    fu_q <= fu_d;
  end

  assign done_o          = done_q;
  assign fwd_right_o     = fr_q;
  assign fwd_down_o      = fd_q;
  assign fwd_left_o      = fl_q;
  assign fwd_up_o        = fu_q;
  // Every packet is consumed here as well.
  assign deliver_local_o = 1'b1;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // Every accepted header yields its decision after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("forwarding decision missing after pipeline latency");

  // The divider leaves a remainder below the column count.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl[DIV_STAGES].valid |-> ((mc < c) && (sc < c)))
    else $error("divider remainder not below column count");

  // No tree ever sends copies both ways along one ring.
  a_no_lr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(fwd_left_o && fwd_right_o))
    else $error("copies sent both left and right");

  a_no_ud: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(fwd_up_o && fwd_down_o))
    else $error("copies sent both up and down");

  // A node outside the torus forwards nothing.
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl[DIV_STAGES].valid && !in_range) |=>
      !(fwd_right_o || fwd_down_o || fwd_left_o || fwd_up_o))
    else $error("forwarding from a node outside the torus");

endmodule

// ----- rtl/tbfs_div_stage.sv -----
module tbfs_div_stage #(
  parameter int unsigned DIM_W = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbfs_pkg::ctl_t                ctl_i,
  input  logic [DIM_W-1:0]              cols_i,
  input  logic [DIM_W-1:0]              rows_i,
  input  logic [tbfs_pkg::DATA_W-1:0]   src_qd_i,
  input  logic [DIM_W-1:0]              src_rem_i,
  input  logic [tbfs_pkg::DATA_W-1:0]   node_qd_i,
  input  logic [DIM_W-1:0]              node_rem_i,
  output tbfs_pkg::ctl_t                ctl_o,
  output logic [DIM_W-1:0]              cols_o,
  output logic [DIM_W-1:0]              rows_o,
  output logic [tbfs_pkg::DATA_W-1:0]   src_qd_o,
  output logic [DIM_W-1:0]              src_rem_o,
  output logic [tbfs_pkg::DATA_W-1:0]   node_qd_o,
  output logic [DIM_W-1:0]              node_rem_o
);
  import tbfs_pkg::*;

  // The qd word holds the dividend bits still to be consumed at the top and
  // the quotient bits already produced at the bottom.
  function automatic logic [DIM_W+DATA_W-1:0] div_step(
    input logic [DIM_W-1:0]  rem,
    input logic [DATA_W-1:0] qd,
    input logic [DIM_W-1:0]  divisor
  );
    logic [DIM_W:0]   trial;
    logic [DIM_W:0]   diff;
    logic             fits;
    logic [DIM_W-1:0] rem_n;
    begin
      trial = {rem, qd[DATA_W-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});
      rem_n = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      div_step = {rem_n, qd[DATA_W-2:0], fits};
    end
  endfunction

  logic [DIM_W-1:0]  src_rem_d, node_rem_d;
  logic [DATA_W-1:0] src_qd_d, node_qd_d;

  always_comb begin
    logic [DIM_W+DATA_W-1:0] s;
    logic [DIM_W+DATA_W-1:0] n;
    s = {src_rem_i, src_qd_i};
    n = {node_rem_i, node_qd_i};
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      s = div_step(s[DIM_W+DATA_W-1:DATA_W], s[DATA_W-1:0], cols_i);
      n = div_step(n[DIM_W+DATA_W-1:DATA_W], n[DATA_W-1:0], cols_i);
    end
    src_rem_d  = s[DIM_W+DATA_W-1:DATA_W];
    src_qd_d   = s[DATA_W-1:0];
    node_rem_d = n[DIM_W+DATA_W-1:DATA_W];
    node_qd_d  = n[DATA_W-1:0];
  end

  logic [DIM_W-1:0]  cols_q, rows_q, src_rem_q, node_rem_q;
  logic [DATA_W-1:0] src_qd_q, node_qd_q;
  tree_e             tree_q;
  logic              valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tree_q     <= ctl_i.tree;
    cols_q     <= cols_i;
    rows_q     <= rows_i;
    src_qd_q   <= src_qd_d;
    src_rem_q  <= src_rem_d;
    node_qd_q  <= node_qd_d;
    node_rem_q <= node_rem_d;
  end

  assign ctl_o      = '{valid: valid_q, tree: tree_q};
  assign cols_o     = cols_q;
  assign rows_o     = rows_q;
  assign src_qd_o   = src_qd_q;
  assign src_rem_o  = src_rem_q;
  assign node_qd_o  = node_qd_q;
  assign node_rem_o = node_rem_q;

endmodule
